### design/lssd_pkg.sv
package lssd_pkg;

    // Frame geometry
    localparam int unsigned HeaderLen = 7;
    localparam int unsigned NodeLen   = 5;
    localparam int unsigned FrameBuf  = 6;
    localparam int unsigned MinSize   = 5;

    // Widths
    localparam int unsigned PosW   = 3;
    localparam int unsigned DataW  = 40;
    localparam int unsigned CfgIdxW = 2;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_SYNC_FIRST    = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_SYNC_SECOND   = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_EXPECTED_TYPE = 2'd2;

    // Reset values of the configuration registers
    localparam logic [7:0] SyncFirstRst    = 8'hA5;
    localparam logic [7:0] SyncSecondRst   = 8'h5A;
    localparam logic [7:0] ExpectedTypeRst = 8'h81;

    // Check bit of node byte 1
    localparam logic [7:0] CheckBit = 8'h01;

    typedef enum logic [1:0] {
        KIND_NODE       = 2'd0,
        KIND_HDR_OK     = 2'd1,
        KIND_WRONG_TYPE = 2'd2,
        KIND_TOO_SHORT  = 2'd3
    } t_kind;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       await_header;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic        start_flag;
        logic [5:0]  quality;
        logic [14:0] angle_q6;
        logic [15:0] dist_qmm;
        logic [29:0] answer_size;
        logic [1:0]  answer_subtype;
        logic [7:0]  answer_type;
    } t_out_beat;

    // Completed frame handed from front to back.
    // Header: data = {type, size word}; node: data = {byte4, byte3, byte2, byte1, byte0}
    typedef struct packed {
        t_kind             kind;
        logic [DataW-1:0]  data;
    } t_frame;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

### design/lssd_front.sv
module lssd_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [lssd_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  logic [7:0]                i_cfg_wdata,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  lssd_pkg::t_in_beat        i_in_beat,
    input  lssd_pkg::t_q_status       i_q_status,
    output logic                      o_push,
    output lssd_pkg::t_frame          o_frame
);
    import lssd_pkg::*;

    logic [7:0]      r_sync_first;
    logic [7:0]      r_sync_second;
    logic [7:0]      r_expected_type;
    logic            r_node_mode;
    logic            n_node_mode;
    logic [PosW-1:0] r_pos;
    logic [PosW-1:0] n_pos;
    logic [7:0]      r_frame [FrameBuf];

    logic            accept;
    logic            mode;
    logic [PosW-1:0] pos;
    logic [7:0]      b;
    logic            store;
    logic [31:0]     size_word;

    assign o_in_stall = i_q_status.full;
    assign accept     = i_in_valid && !i_q_status.full;
    assign b          = i_in_beat.rx_byte;
    assign mode       = i_in_beat.await_header ? 1'b0 : r_node_mode;
    assign pos        = i_in_beat.await_header ? '0 : r_pos;
    assign size_word  = {r_frame[5], r_frame[4], r_frame[3], r_frame[2]};

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first    <= SyncFirstRst;
            r_sync_second   <= SyncSecondRst;
            r_expected_type <= ExpectedTypeRst;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SYNC_FIRST:    r_sync_first    <= i_cfg_wdata;
                CFG_SYNC_SECOND:   r_sync_second   <= i_cfg_wdata;
                CFG_EXPECTED_TYPE: r_expected_type <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Classify the byte against mode and position
    always_comb begin
        n_node_mode = mode;
        n_pos       = pos;
        store       = 1'b0;
        o_push      = 1'b0;
        o_frame     = '{kind: KIND_NODE, data: '0};
        if (!mode) begin
            if (pos == '0) begin
                if (b == r_sync_first) begin
                    store = 1'b1;
                    n_pos = pos + 1'b1;
                end
            end else if (pos == PosW'(1)) begin
                if (b != r_sync_second) begin
                    n_pos = '0;
                end else begin
                    store = 1'b1;
                    n_pos = pos + 1'b1;
                end
            end else if (pos < PosW'(HeaderLen - 1)) begin
                store = 1'b1;
                n_pos = pos + 1'b1;
            end else begin
                // header complete
                n_pos        = '0;
                o_push       = accept;
                o_frame.data = {b, size_word};
                if (b != r_expected_type) begin
                    o_frame.kind = KIND_WRONG_TYPE;
                end else if (size_word[29:0] < 30'(MinSize)) begin
                    o_frame.kind = KIND_TOO_SHORT;
                end else begin
                    o_frame.kind = KIND_HDR_OK;
                    n_node_mode  = 1'b1;
                end
            end
        end else begin
            if (pos == '0) begin
                if (b[0] ^ b[1]) begin
                    store = 1'b1;
                    n_pos = pos + 1'b1;
                end
            end else if (pos == PosW'(1)) begin
                if ((b & CheckBit) == 8'h00) begin
                    n_pos = '0;
                end else begin
                    store = 1'b1;
                    n_pos = pos + 1'b1;
                end
            end else if (pos < PosW'(NodeLen - 1)) begin
                store = 1'b1;
                n_pos = pos + 1'b1;
            end else begin
                // node complete
                n_pos        = '0;
                o_push       = accept;
                o_frame.kind = KIND_NODE;
                o_frame.data = {b, r_frame[3], r_frame[2], r_frame[1], r_frame[0]};
            end
        end
    end

    // Mode and position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_mode <= 1'b0;
            r_pos       <= '0;
        end else if (accept) begin
            r_node_mode <= n_node_mode;
            r_pos       <= n_pos;
        end
    end

    // Frame byte store, no reset
    always_ff @(posedge i_clk) begin
        if (accept && store) begin
            case (pos)
                3'd0: r_frame[0] <= b;
                3'd1: r_frame[1] <= b;
                3'd2: r_frame[2] <= b;
                3'd3: r_frame[3] <= b;
                3'd4: r_frame[4] <= b;
                3'd5: r_frame[5] <= b;
                default: ;
            endcase
        end
    end

endmodule

### design/lssd_queue.sv
module lssd_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  lssd_pkg::t_frame    i_frame,
    input  logic                i_pop,
    output lssd_pkg::t_frame    o_frame,
    output lssd_pkg::t_q_status o_status
);
    import lssd_pkg::*;

    t_frame      r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic        do_push;
    logic        do_pop;

    assign o_status.full  = (r_count == 2'd2);
    assign o_status.empty = (r_count == 2'd0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_frame        = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_frame;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) r_wr_ptr <= !r_wr_ptr;
            if (do_pop)  r_rd_ptr <= !r_rd_ptr;
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### design/lssd_back.sv
module lssd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lssd_pkg::t_frame    i_frame,
    input  lssd_pkg::t_q_status i_q_status,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lssd_pkg::t_out_beat o_out_beat
);
    import lssd_pkg::*;

    logic      r_valid;
    t_out_beat r_beat;
    t_out_beat n_beat;
    logic      load;

    assign load        = !i_q_status.empty && (!r_valid || !i_out_stall);
    assign o_pop       = load;
    assign o_out_valid = r_valid;
    assign o_out_beat  = r_beat;

    // Unpack a frame into result fields
    always_comb begin
        n_beat             = '0;
        n_beat.result_kind = i_frame.kind;
        case (i_frame.kind)
            KIND_NODE: begin
                n_beat.start_flag = i_frame.data[0];
                n_beat.quality    = i_frame.data[7:2];
                n_beat.angle_q6   = i_frame.data[23:9];
                n_beat.dist_qmm   = i_frame.data[39:24];
            end
            default: begin
                n_beat.answer_size    = i_frame.data[29:0];
                n_beat.answer_subtype = i_frame.data[31:30];
                n_beat.answer_type    = i_frame.data[39:32];
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_beat <= n_beat;
        end
    end

endmodule

### design/lidar_scan_stream_deframer.sv
// A completed frame is written into the queue, then unpacked into the output register.
// One byte per cycle unless the queue is full; front mode and position update per byte.
// A two-entry frame queue and the output register let the front run on while results wait.
// Reset (synchronous, active low): header hunting at position 0, sync/type registers
// back to A5h/5Ah/81h, queue and output empty; frame bytes are not cleared.
module lidar_scan_stream_deframer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [lssd_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  logic [7:0]                   i_cfg_wdata,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  lssd_pkg::t_in_beat           i_in_beat,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output lssd_pkg::t_out_beat          o_out_beat
);
    import lssd_pkg::*;

    logic      push;
    logic      pop;
    t_frame    push_frame;
    t_frame    head_frame;
    t_q_status q_status;

    lssd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_frame     (push_frame)
    );

    lssd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_frame  (push_frame),
        .i_pop    (pop),
        .o_frame  (head_frame),
        .o_status (q_status)
    );

    lssd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_frame     (head_frame),
        .i_q_status  (q_status),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat)
    );

endmodule
